// ----- hdl/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");

`define ASSERT_CLK_NR(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

// ----- hdl/lfdf_pkg.sv -----
package lfdf_pkg;
  localparam int COLUMNS = 84;
  localparam int ROW_GROUPS = 6;
  localparam int CW = 7;
  localparam int GW = 3;
  localparam int AW = 9;
  localparam int DEPTH = COLUMNS * ROW_GROUPS;
  localparam int QDEPTH = 2;

  localparam logic [2:0] ACT_WPIX = 3'd0;
  localparam logic [2:0] ACT_WBYTE = 3'd1;
  localparam logic [2:0] ACT_RPIX = 3'd2;
  localparam logic [2:0] ACT_RBYTE = 3'd3;
  localparam logic [2:0] ACT_FSTART = 3'd4;
  localparam logic [2:0] ACT_FSTEP = 3'd5;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  localparam logic [7:0] CMD_MODE = 8'h20;
  localparam logic [7:0] CMD_ROW = 8'h40;
  localparam logic [7:0] CMD_COL = 8'h80;

  // classified operation passed from front to back
  typedef struct packed {
    logic [2:0]      op;
    logic            ok;
    logic [GW-1:0]   grp;
    logic [CW-1:0]   col;
    logic [2:0]      bitn;
    logic [7:0]      val;
    logic            clr;
  } op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_v;
    logic       is_data;
    logic       pixel_bit;
    logic       full_mode;
    logic       flush_done;
    logic       last;
  } res_t;
endpackage

// ----- hdl/lfdf_ram.sv -----
module lfdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

// ----- hdl/lfdf_front.sv -----
module lfdf_front import lfdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  output logic        q_valid,
  input  logic        q_ready,
  output op_t         q_op
);
  op_t       q_r [QDEPTH];
  logic      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  op_t       cls;
  logic [2:0] act;
  logic [5:0] prow;
  logic [2:0] rg;
  logic [6:0] col;
  logic      push, pop;

  assign act  = in_tdata[2:0];
  assign prow = in_tdata[8:3];
  assign rg   = in_tdata[11:9];
  assign col  = in_tdata[18:12];

  always_comb begin
    cls = '0;
    cls.op  = act;
    cls.col = col;
    cls.val = in_tdata[26:19];
    cls.clr = in_tdata[27];
    if (act == ACT_WPIX || act == ACT_RPIX) begin
      cls.grp  = prow[5:3];
      cls.bitn = prow[2:0];
      cls.ok   = ({1'b0, prow[5:3]} < 4'(ROW_GROUPS)) && ({1'b0, col} < 8'(COLUMNS));
    end else begin
      cls.grp  = rg;
      cls.bitn = 3'd0;
      cls.ok   = ({1'b0, rg} < 4'(ROW_GROUPS)) && ({1'b0, col} < 8'(COLUMNS));
    end
  end

  assign in_tready = (cnt_r != 2'(QDEPTH));
  assign push = in_tvalid && in_tready && act <= ACT_FSTEP;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_op = q_r[rp_r];

  always_comb begin
    wp_nxt = wp_r ^ push;
    rp_nxt = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end
endmodule

// ----- hdl/lfdf_back.sv -----
`include "assert_macros.svh"
module lfdf_back import lfdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_tvalid,
  output logic       cfg_tready,
  input  logic [8:0] cfg_tdata,
  input  logic       q_valid,
  output logic       q_ready,
  input  op_t        q_op,
  output logic       out_tvalid,
  input  logic       out_tready,
  output res_t       out_res
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_SCLR = 3'd5;
  localparam logic [2:0] S_INIT = 3'd6;

  logic [2:0]  st_r, st_nxt;
  op_t         op_r;
  logic [8:0]  thr_r;
  logic        fact_r, ffull_r, run_r;
  logic [GW-1:0] sg_r;
  logic [CW-1:0] sc_r;
  logic [AW-1:0] init_r;
  logic [ROW_GROUPS-1:0] dprev_r;
  logic [CW-1:0] scol_r;
  logic [9:0]  tot_r;
  logic [9:0]  cons_r;
  logic [1:0]  emi_r;
  logic [1:0]  ecnt_r;
  logic        edone_r, ehdr_r;
  logic [7:0]  ebyte_r;
  logic [GW-1:0] eg_r;
  logic [CW-1:0] ec_r;

  logic        ram_we, wr_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [7:0]  ram_wd, ram_rd;
  logic        d_we;
  logic [CW-1:0] d_wa, d_ra;
  logic [ROW_GROUPS-1:0] d_wd, d_rd;
  logic [AW-1:0] addr;
  logic [7:0]  nb;
  logic        dbit;
  logic [GW-1:0] cg;
  logic [CW-1:0] cc;
  logic        done;
  logic [2:0]  pc_d, pc_c;
  logic signed [12:0] weighted;
  logic signed [12:0] wfin;

  function automatic logic [2:0] pop6(input logic [ROW_GROUPS-1:0] v);
    logic [2:0] s;
    s = '0;
    for (int i = 0; i < ROW_GROUPS; i++) s = s + 3'(v[i]);
    return s;
  endfunction

  assign cg = (op_r.op == ACT_FSTEP) ? sg_r : op_r.grp;
  assign cc = (op_r.op == ACT_FSTEP) ? sc_r : op_r.col;
  assign addr = AW'(cg) * AW'(COLUMNS) + AW'(cc);
  assign ram_ra = addr;
  assign dbit = d_rd[cg];
  assign done = (sg_r == GW'(ROW_GROUPS - 1)) && (sc_r == CW'(COLUMNS - 1));

  always_comb begin
    nb = ram_rd;
    if (op_r.op == ACT_WPIX) begin
      nb[op_r.bitn] = op_r.val[0];
    end else begin
      nb = op_r.val;
    end
  end

  assign wr_we = (st_r == S_EXEC) && op_r.ok && nb != ram_rd &&
                 (op_r.op == ACT_WPIX || op_r.op == ACT_WBYTE);
  assign ram_we = (st_r == S_INIT) || wr_we;
  assign ram_wa = (st_r == S_INIT) ? init_r : addr;
  assign ram_wd = (st_r == S_INIT) ? 8'd0 : nb;

  lfdf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  // dirty bits, one word per column
  always_comb begin
    if (st_r == S_SCLR) begin
      d_ra = '0;
    end else if (st_r == S_SCAN && scol_r != CW'(COLUMNS - 1)) begin
      d_ra = scol_r + 1'b1;
    end else if (st_r == S_SCAN) begin
      d_ra = scol_r;
    end else begin
      d_ra = cc;
    end
  end

  always_comb begin
    d_we = 1'b0;
    d_wa = cc;
    d_wd = d_rd;
    if (st_r == S_INIT) begin
      d_we = (init_r < AW'(COLUMNS));
      d_wa = init_r[CW-1:0];
      d_wd = '1;
    end else if (st_r == S_EXEC) begin
      case (op_r.op)
        ACT_WPIX, ACT_WBYTE: begin
          if (wr_we) begin
            d_we = 1'b1;
            d_wd[cg] = 1'b1;
          end
        end
        ACT_RPIX, ACT_RBYTE: begin
          if (op_r.ok && op_r.clr) begin
            d_we = 1'b1;
            d_wd[cg] = 1'b0;
          end
        end
        ACT_FSTEP: begin
          if (fact_r && (ffull_r || dbit)) begin
            d_we = 1'b1;
            d_wd[cg] = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  lfdf_ram #(.WIDTH(ROW_GROUPS), .DEPTH(COLUMNS)) u_dirty (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd),
    .raddr(d_ra), .rdata(d_rd)
  );

  assign pc_d = pop6(d_rd);
  assign pc_c = pop6(d_rd & dprev_r);
  assign weighted = $signed({3'b0, tot_r}) - $signed({1'b0, cons_r, 2'b0})
                    + $signed({3'b0, cons_r});

  // full-mode decision: consecutive pairs counted against previous column
  assign wfin = weighted + $signed({10'b0, pc_d}) - $signed({8'b0, pc_c, 2'b0})
                + $signed({10'b0, pc_c});

  assign cfg_tready = (st_r == S_IDLE);
  assign q_ready = (st_r == S_IDLE) && !cfg_tvalid;
  assign out_tvalid = (st_r == S_EMIT);

  always_comb begin
    out_res = '0;
    out_res.full_mode = ffull_r;
    out_res.flush_done = edone_r;
    if (emi_r == 2'd0 && ecnt_r == 2'd0 && !ehdr_r) begin
      out_res.kind = op_r.op == ACT_FSTEP ? KIND_STAT : KIND_READ;
      out_res.byte_v = ebyte_r;
      out_res.pixel_bit = (op_r.op == ACT_RPIX) ? ebyte_r[op_r.bitn] : 1'b0;
      out_res.last = 1'b1;
      if (op_r.op == ACT_FSTEP && ecnt_r == 2'd0) out_res.byte_v = 8'd0;
    end else begin
      out_res.kind = KIND_BYTE;
      case (emi_r)
        2'd0: out_res.byte_v = CMD_MODE;
        2'd1: out_res.byte_v = CMD_ROW + 8'(eg_r);
        2'd2: out_res.byte_v = CMD_COL + 8'(ec_r);
        default: begin
          out_res.byte_v = ebyte_r;
          out_res.is_data = 1'b1;
          out_res.last = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (!cfg_tvalid && q_valid) st_nxt = (q_op.op == ACT_FSTART) ? S_SCLR : S_RD;
      S_RD:   st_nxt = S_EXEC;
      S_EXEC: begin
        if (op_r.op == ACT_RPIX || op_r.op == ACT_RBYTE ||
            (op_r.op == ACT_FSTEP && fact_r)) begin
          st_nxt = S_EMIT;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_EMIT: if (out_tready && out_res.last) st_nxt = S_IDLE;
      S_SCLR: st_nxt = S_SCAN;
      S_SCAN: if (scol_r == CW'(COLUMNS - 1)) st_nxt = S_IDLE;
      S_INIT: if (init_r == AW'(DEPTH - 1)) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT;
      init_r <= '0;
      thr_r <= 9'd168;
      fact_r <= 1'b0;
      ffull_r <= 1'b0;
      run_r <= 1'b0;
      sg_r <= '0;
      sc_r <= '0;
      emi_r <= '0;
      ecnt_r <= '0;
      ehdr_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_tvalid && cfg_tready) thr_r <= cfg_tdata;
      case (st_r)
        S_INIT: init_r <= init_r + 1'b1;
        S_IDLE: if (!cfg_tvalid && q_valid) op_r <= q_op;
        S_EXEC: begin
          ebyte_r <= (op_r.ok || op_r.op == ACT_FSTEP) ? ram_rd : 8'd0;
          edone_r <= 1'b0;
          emi_r <= '0;
          ecnt_r <= '0;
          ehdr_r <= 1'b0;
          case (op_r.op)
            ACT_FSTEP: begin
              if (fact_r) begin
                edone_r <= done;
                eg_r <= sg_r;
                ec_r <= sc_r;
                if (ffull_r || dbit) begin
                  ecnt_r <= 2'd1;
                  if (ffull_r ? (sg_r == '0 && sc_r == '0) : !run_r) begin
                    ehdr_r <= 1'b1;
                  end else begin
                    emi_r <= 2'd3;
                  end
                  if (!ffull_r) run_r <= 1'b1;
                end else begin
                  run_r <= 1'b0;
                end
                if (done) begin
                  fact_r <= 1'b0;
                end else if (sc_r == CW'(COLUMNS - 1)) begin
                  sc_r <= '0;
                  sg_r <= sg_r + 1'b1;
                end else begin
                  sc_r <= sc_r + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        S_EMIT: if (out_tready && !out_res.last) emi_r <= emi_r + 1'b1;
        S_SCLR: begin
          scol_r <= '0;
          tot_r <= '0;
          cons_r <= '0;
          dprev_r <= '0;
        end
        S_SCAN: begin
          scol_r <= scol_r + 1'b1;
          dprev_r <= d_rd;
          tot_r <= tot_r + 10'(pc_d);
          cons_r <= cons_r + 10'(pc_c);
          if (scol_r == CW'(COLUMNS - 1)) begin
            fact_r <= 1'b1;
            ffull_r <= (wfin >= $signed({4'b0, thr_r}));
            sg_r <= '0;
            sc_r <= '0;
            run_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_emit_from_exec, $rose(out_tvalid) |-> $past(st_r) == S_EXEC)
  `ASSERT_CLK(a_no_take_busy, q_ready |-> st_r == S_IDLE)
  `ASSERT_CLK(a_cfg_idle, (cfg_tvalid && cfg_tready) |=> st_r == S_IDLE)
endmodule

// ----- hdl/lcd_framebuffer_dirty_flush.sv -----
// a read gives one reply; a flush step gives up to 4 results
// requests are handled one at a time by a frame ram read-modify-write; a two-entry queue buffers input
// flush start scans the dirty bits, one column per cycle
// reset: synchronous active-low rst_n; dirty bits all set, threshold 168, flush idle
// after reset an init pass zeroes the frame ram; transactions wait until it ends
module lcd_framebuffer_dirty_flush import lfdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // action, pixel_row, row_group, column, value, clear_dirty
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [8:0]  cfg_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // out_byte, pixel_bit, full_mode, flush_done
  output logic [2:0]  out_tuser, // kind, is_data
  output logic        out_tlast
);
  logic q_valid, q_ready;
  op_t  q_op;
  res_t res;

  lfdf_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op)
  );

  lfdf_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready),
    .cfg_tdata(cfg_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_res(res)
  );

  assign out_tdata = {5'b0, res.flush_done, res.full_mode, res.pixel_bit, res.byte_v};
  assign out_tuser = {res.is_data, res.kind};
  assign out_tlast = res.last;
endmodule

// ----- test/lcd_framebuffer_dirty_flush_tb.sv -----
module lcd_framebuffer_dirty_flush_tb;
  import lfdf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       is_data;
    logic       pixel_bit;
    logic       full_mode;
    logic       flush_done;
    logic       last;
  } lcd_reply_t;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] pixel_row;
    logic [2:0] row_group;
    logic [6:0] column;
    logic [7:0] value;
    logic       clear_dirty;
  } lcd_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;  // action, pixel_row, row_group, column, value, clear_dirty
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [8:0]  cfg_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata; // out_byte, pixel_bit, full_mode, flush_done
  logic [2:0]  out_tuser; // kind, is_data
  logic        out_tlast;

  lcd_framebuffer_dirty_flush uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // shadow of the display controller
  logic [8:0] shadow_threshold;
  logic [7:0] shadow_frame [ROW_GROUPS][COLUMNS];
  logic [5:0] shadow_dirty [COLUMNS];
  logic       shadow_flushing;
  logic       shadow_full;
  int         shadow_group;
  int         shadow_column;
  logic       shadow_run;

  lcd_reply_t pending_replies[$];
  int         mismatches;
  int         burst_left;
  bit         sender_idles;
  int         stall_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic lcd_reply_t make_reply(logic [1:0] kind, logic [7:0] b,
                                            logic is_data, logic pix);
    lcd_reply_t r;
    r = '0;
    r.kind = kind;
    r.data_byte = b;
    r.is_data = is_data;
    r.pixel_bit = pix;
    return r;
  endfunction

  task automatic predict_display(input lcd_req_t rq);
    lcd_reply_t part[$];
    int g, c, bitn, total, consec;
    logic ok, done;
    logic [7:0] old_b, new_b, b;
    done = 1'b0;
    case (rq.action)
      ACT_WPIX, ACT_RPIX: begin
        g = rq.pixel_row >> 3;
        bitn = rq.pixel_row & 7;
        c = rq.column;
        ok = (g < ROW_GROUPS) && (c < COLUMNS);
        if (rq.action == ACT_WPIX) begin
          if (ok) begin
            old_b = shadow_frame[g][c];
            new_b = old_b;
            new_b[bitn] = rq.value[0];
            if (new_b != old_b) begin
              shadow_frame[g][c] = new_b;
              shadow_dirty[c][g] = 1'b1;
            end
          end
        end else begin
          b = 8'h00;
          if (ok) begin
            b = shadow_frame[g][c];
            if (rq.clear_dirty) shadow_dirty[c][g] = 1'b0;
          end
          part.push_back(make_reply(KIND_READ, b, 1'b0, b[bitn]));
        end
      end
      ACT_WBYTE, ACT_RBYTE: begin
        g = rq.row_group;
        c = rq.column;
        ok = (g < ROW_GROUPS) && (c < COLUMNS);
        if (rq.action == ACT_WBYTE) begin
          if (ok && shadow_frame[g][c] != rq.value) begin
            shadow_frame[g][c] = rq.value;
            shadow_dirty[c][g] = 1'b1;
          end
        end else begin
          b = 8'h00;
          if (ok) begin
            b = shadow_frame[g][c];
            if (rq.clear_dirty) shadow_dirty[c][g] = 1'b0;
          end
          part.push_back(make_reply(KIND_READ, b, 1'b0, 1'b0));
        end
      end
      ACT_FSTART: begin
        total = 0;
        consec = 0;
        for (int cc = 0; cc < COLUMNS; cc++)
          for (int gg = 0; gg < ROW_GROUPS; gg++)
            if (shadow_dirty[cc][gg]) begin
              total++;
              if (cc + 1 < COLUMNS && shadow_dirty[cc + 1][gg]) consec++;
            end
        shadow_full = (total - 3 * consec) >= int'(shadow_threshold);
        shadow_flushing = 1'b1;
        shadow_group = 0;
        shadow_column = 0;
        shadow_run = 1'b0;
      end
      ACT_FSTEP: begin
        if (shadow_flushing) begin
          g = shadow_group;
          c = shadow_column;
          b = shadow_frame[g][c];
          done = (g == ROW_GROUPS - 1) && (c == COLUMNS - 1);
          if (shadow_full || shadow_dirty[c][g]) begin
            if (shadow_full ? (g == 0 && c == 0) : !shadow_run) begin
              part.push_back(make_reply(KIND_BYTE, CMD_MODE, 1'b0, 1'b0));
              part.push_back(make_reply(KIND_BYTE, CMD_ROW + 8'(g), 1'b0, 1'b0));
              part.push_back(make_reply(KIND_BYTE, CMD_COL + 8'(c), 1'b0, 1'b0));
            end
            part.push_back(make_reply(KIND_BYTE, b, 1'b1, 1'b0));
            shadow_dirty[c][g] = 1'b0;
            if (!shadow_full) shadow_run = 1'b1;
          end else begin
            shadow_run = 1'b0;
            part.push_back(make_reply(KIND_STAT, 8'h00, 1'b0, 1'b0));
          end
          if (done) shadow_flushing = 1'b0;
          else if (c + 1 >= COLUMNS) begin
            shadow_column = 0;
            shadow_group = g + 1;
          end else shadow_column = c + 1;
        end
      end
      default: ;
    endcase
    foreach (part[k]) begin
      part[k].full_mode = shadow_full;
      part[k].flush_done = done;
      part[k].last = (k == part.size() - 1);
      pending_replies.push_back(part[k]);
    end
  endtask

  task automatic send_request(input lcd_req_t rq);
    bit taken;
    int gap;
    gap = 0;
    if (sender_idles) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, rq.clear_dirty, rq.value, rq.column, rq.row_group,
                 rq.pixel_row, rq.action};
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = in_tready;
    end
    predict_display(rq);
    @(negedge clk);
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [8:0] thr);
    bit taken;
    drain_replies();
    cfg_tvalid <= 1'b1;
    cfg_tdata <= thr;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = cfg_tready;
    end
    shadow_threshold = thr;
    @(negedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  function automatic lcd_req_t req(logic [2:0] act, int prow, int rg, int col,
                                   int val, bit clr);
    lcd_req_t r;
    r.action = act;
    r.pixel_row = 6'(prow);
    r.row_group = 3'(rg);
    r.column = 7'(col);
    r.value = 8'(val);
    r.clear_dirty = clr;
    return r;
  endfunction

  function automatic lcd_req_t random_access();
    lcd_req_t r;
    bit wild;
    wild = ($urandom_range(0, 9) == 0);
    r = req(3'($urandom_range(0, 3)), $urandom_range(0, wild ? 63 : 47),
            $urandom_range(0, wild ? 7 : 5), $urandom_range(0, wild ? 127 : 83),
            $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    return r;
  endfunction

  task automatic run_flush_steps(input int n);
    repeat (n) send_request(req(ACT_FSTEP, $urandom_range(0, 63), $urandom_range(0, 7),
                                $urandom_range(0, 127), $urandom_range(0, 255),
                                1'($urandom_range(0, 1))));
  endtask

  task automatic test_access_edges();
    send_request(req(ACT_WPIX, 0, 0, 0, 1, 0));
    send_request(req(ACT_WPIX, 47, 0, 83, 8'hFE, 0));
    send_request(req(ACT_RPIX, 47, 0, 83, 0, 0));
    send_request(req(ACT_RPIX, 0, 0, 0, 0, 1));
    send_request(req(ACT_WBYTE, 0, 5, 83, 255, 0));
    send_request(req(ACT_WBYTE, 0, 5, 83, 255, 0));
    send_request(req(ACT_RBYTE, 63, 5, 83, 0, 1));
    send_request(req(ACT_WBYTE, 0, 0, 0, 0, 0));
    send_request(req(ACT_RBYTE, 0, 0, 0, 0, 0));
    // out of range addresses
    send_request(req(ACT_WPIX, 63, 0, 10, 1, 0));
    send_request(req(ACT_WBYTE, 0, 7, 10, 8'hA5, 0));
    send_request(req(ACT_WBYTE, 0, 2, 127, 8'h5A, 0));
    send_request(req(ACT_RPIX, 48, 0, 3, 0, 1));
    send_request(req(ACT_RBYTE, 0, 6, 3, 0, 1));
    send_request(req(ACT_RBYTE, 0, 1, 84, 0, 1));
    // undefined actions and step with no flush running
    send_request(req(3'd6, 63, 7, 127, 255, 1));
    send_request(req(3'd7, 0, 0, 0, 0, 0));
    send_request(req(ACT_FSTEP, 0, 0, 0, 0, 0));
  endtask

  // nearly all bytes dirty and adjacent, so the weighted count goes negative
  task automatic test_partial_all_dirty();
    write_threshold(9'd0);
    send_request(req(ACT_FSTART, 0, 0, 0, 0, 0));
    run_flush_steps(30);
  endtask

  task automatic test_full_refresh();
    send_request(req(ACT_FSTART, 0, 0, 0, 0, 0));
    run_flush_steps(20);
  endtask

  task automatic test_sparse_partial();
    write_threshold(9'd504);
    for (int i = 0; i < 6; i++)
      send_request(req(ACT_WBYTE, 0, $urandom_range(0, 5), $urandom_range(0, 83),
                       $urandom_range(0, 255), 0));
    send_request(req(ACT_WBYTE, 0, 5, 83, 8'h3C, 0));
    send_request(req(ACT_WBYTE, 0, 1, 83, 8'h11, 0));
    send_request(req(ACT_WBYTE, 0, 2, 0, 8'h22, 0));
    send_request(req(ACT_FSTART, 0, 0, 0, 0, 0));
    run_flush_steps(30);
  endtask

  task automatic test_restart_midflush();
    write_threshold(9'd168);
    send_request(req(ACT_WBYTE, 0, 0, 1, 8'h81, 0));
    send_request(req(ACT_FSTART, 0, 0, 0, 0, 0));
    run_flush_steps(5);
    send_request(req(ACT_WPIX, 2, 0, 0, 1, 0));
    send_request(req(ACT_FSTART, 0, 0, 0, 0, 0));
    run_flush_steps(10);
  endtask

  task automatic test_random_traffic();
    int sel;
    write_threshold(9'($urandom_range(0, 504)));
    for (int i = 0; i < 30; i++) begin
      if (i == 15) begin
        write_threshold(9'($urandom_range(0, 40)));
        sender_idles = 0;
      end
      if (i == 22) sender_idles = 1;
      sel = $urandom_range(0, 99);
      if (sel < 45) send_request(random_access());
      else if (sel < 50) send_request(req(ACT_FSTART, 0, 0, 0, 0, 0));
      else if (sel < 95) run_flush_steps(1);
      else send_request(req(3'($urandom_range(6, 7)), $urandom_range(0, 63),
                            $urandom_range(0, 7), $urandom_range(0, 127),
                            $urandom_range(0, 255), 1'($urandom_range(0, 1))));
    end
  endtask

  always @(posedge clk) begin
    lcd_reply_t want;
    lcd_reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[1:0], out_tdata[7:0], out_tuser[2], out_tdata[8], out_tdata[9],
             out_tdata[10], out_tlast};
      if (pending_replies.size() == 0)
        report_mismatch("unexpected result", {1'b0, got}, 16'h0);
      else begin
        want = pending_replies.pop_front();
        if (got.kind != want.kind)
          report_mismatch("kind", 16'(got.kind), 16'(want.kind));
        if (got.data_byte != want.data_byte)
          report_mismatch("out_byte", 16'(got.data_byte), 16'(want.data_byte));
        if (got.is_data != want.is_data)
          report_mismatch("is_data", 16'(got.is_data), 16'(want.is_data));
        if (got.pixel_bit != want.pixel_bit)
          report_mismatch("pixel_bit", 16'(got.pixel_bit), 16'(want.pixel_bit));
        if (got.full_mode != want.full_mode)
          report_mismatch("full_mode", 16'(got.full_mode), 16'(want.full_mode));
        if (got.flush_done != want.flush_done)
          report_mismatch("flush_done", 16'(got.flush_done), 16'(want.flush_done));
        if (got.last != want.last)
          report_mismatch("tlast", 16'(got.last), 16'(want.last));
      end
    end
  end

  // receiver stall pattern, changing character now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 1) != 0);
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_tvalid = 1'b0;
    cfg_tdata = '0;
    out_tready = 1'b1;
    stall_mode = 0;
    mismatches = 0;
    burst_left = 0;
    sender_idles = 1;
    shadow_threshold = 9'd168;
    foreach (shadow_frame[g, c]) shadow_frame[g][c] = 8'h00;
    foreach (shadow_dirty[c]) shadow_dirty[c] = 6'h3F;
    shadow_flushing = 1'b0;
    shadow_full = 1'b0;
    shadow_group = 0;
    shadow_column = 0;
    shadow_run = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_access_edges();
    test_partial_all_dirty();
    test_full_refresh();
    test_sparse_partial();
    test_restart_midflush();
    test_random_traffic();

    drain_replies();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
